### design/ops_pkg.sv
package ops_pkg;

	// fixed point format and field layout
	localparam int FRAC_BITS = 12;
	localparam int NFIELDS   = 6;
	localparam int OPAC_IDX  = 5;
	localparam int FIELD_W   = 16;
	localparam int OPAC_W    = 13;
	localparam int FLD_W     = $clog2(NFIELDS);
	localparam int OPAC_MAX  = (1 << OPAC_W) - 1;
	localparam int ONE_RAW   = 1 << FRAC_BITS;
	localparam int OPAC_ONE  = (ONE_RAW > OPAC_MAX) ? OPAC_MAX : ONE_RAW;

	// smoothing gain, round(0.28 * 2^FRAC_BITS)
	localparam int ALPHA_Q   = (28 * ONE_RAW + 50) / 100;
	// difference (FIELD_W+1) times positive gain (FRAC_BITS+1)
	localparam int PROD_W    = FIELD_W + 2 + FRAC_BITS;
	localparam int SUM_W     = FIELD_W + 2;

	// miss handling
	localparam int HOLD_FRAMES = 8;
	localparam int FADE_END    = 18;
	localparam int FADE_LEN    = 10;
	localparam int MISS_W      = 5;
	localparam int MISS_MAX    = (1 << MISS_W) - 1;
	localparam int FADE_IDX_W  = 4;

	// frame phase and interval register
	localparam int PHASE_W        = 8;
	localparam int INTERVAL_RESET = 3;

	// command queue between front and back
	localparam int CMDQ_DEPTH = 4;

	typedef struct packed {
		logic                      det_visible;
		logic signed [FIELD_W-1:0] det_center_x;
		logic signed [FIELD_W-1:0] det_center_y;
		logic signed [FIELD_W-1:0] det_width;
		logic signed [FIELD_W-1:0] det_height;
		logic signed [FIELD_W-1:0] det_rotation;
		logic        [OPAC_W-1:0]  det_opacity;
	} det_item_t;

	typedef struct packed {
		logic                      out_visible;
		logic signed [FIELD_W-1:0] out_center_x;
		logic signed [FIELD_W-1:0] out_center_y;
		logic signed [FIELD_W-1:0] out_width;
		logic signed [FIELD_W-1:0] out_height;
		logic signed [FIELD_W-1:0] out_rotation;
		logic        [OPAC_W-1:0]  out_opacity;
		logic                      detection_used;
	} res_item_t;

	typedef logic [NFIELDS-1:0][FIELD_W-1:0] fields_t;

	// work the back end does for one frame
	typedef enum logic [2:0] {
		OP_SKIP   = 3'd0,
		OP_RAW    = 3'd1,
		OP_LOAD   = 3'd2,
		OP_SMOOTH = 3'd3,
		OP_OPAC   = 3'd4
	} op_e;

	typedef struct packed {
		op_e              op;
		logic [OPAC_W-1:0] opac;
		det_item_t        det;
	} cmd_t;

	typedef logic [(1 << FADE_IDX_W)-1:0][OPAC_W-1:0] fade_tbl_t;

	// fade opacity by frames left before the drop
	function automatic fade_tbl_t fade_table();
		fade_tbl_t t;
		int        v;
		for (int i = 0; i < (1 << FADE_IDX_W); i++) begin
			if (i <= FADE_LEN) begin
				v = (OPAC_ONE * i + FADE_LEN / 2) / FADE_LEN;
			end else begin
				v = 0;
			end
			t[i] = OPAC_W'(v);
		end
		return t;
	endfunction

	localparam fade_tbl_t FADE_TBL = fade_table();

	// detection as six field slots, opacity zero extended
	function automatic fields_t det_fields(det_item_t d);
		fields_t f;
		f[0] = d.det_center_x;
		f[1] = d.det_center_y;
		f[2] = d.det_width;
		f[3] = d.det_height;
		f[4] = d.det_rotation;
		f[OPAC_IDX] = FIELD_W'(d.det_opacity);
		return f;
	endfunction

	function automatic res_item_t make_res(logic vis, fields_t f, logic used);
		res_item_t r;
		r.out_visible    = vis;
		r.out_center_x   = f[0];
		r.out_center_y   = f[1];
		r.out_width      = f[2];
		r.out_height     = f[3];
		r.out_rotation   = f[4];
		r.out_opacity    = f[OPAC_IDX][OPAC_W-1:0];
		r.detection_used = used;
		return r;
	endfunction

endpackage

### design/ops_front.sv
module ops_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  ops_pkg::det_item_t           det,
	input  logic                         cfg_wr_en,
	input  logic [ops_pkg::PHASE_W-1:0]  cfg_wr_data,
	input  logic                         cmd_full,
	output logic                         cmd_wr,
	output ops_pkg::cmd_t                cmd
);

	logic [ops_pkg::PHASE_W-1:0] interval_q;
	logic [ops_pkg::PHASE_W-1:0] phase_q;
	logic                        sv_q;
	logic [ops_pkg::MISS_W-1:0]  miss_q;
	logic                        held_vis_q;

	logic [ops_pkg::PHASE_W-1:0] iv;
	logic [ops_pkg::PHASE_W-1:0] ph_inc;
	logic [ops_pkg::PHASE_W-1:0] ph_next;
	logic                        used;
	logic [ops_pkg::MISS_W-1:0]  miss_inc;
	logic [ops_pkg::MISS_W-1:0]  fade_left;
	logic                        sv_d;
	logic [ops_pkg::MISS_W-1:0]  miss_d;
	logic                        hv_d;

	assign cmd_wr = push & ~cmd_full;

	// phase step and consume decision
	always_comb begin
		iv       = (interval_q == '0) ? ops_pkg::PHASE_W'(1) : interval_q;
		ph_inc   = phase_q + ops_pkg::PHASE_W'(1);
		ph_next  = (ph_inc >= iv) ? '0 : ph_inc;
		used     = (ph_next == '0) || !held_vis_q;
		miss_inc = (miss_q == ops_pkg::MISS_W'(ops_pkg::MISS_MAX)) ? miss_q
			: miss_q + ops_pkg::MISS_W'(1);
		fade_left = ops_pkg::MISS_W'(ops_pkg::FADE_END) - miss_inc;
	end

	// classify the frame into one back end command
	always_comb begin
		sv_d     = sv_q;
		miss_d   = miss_q;
		hv_d     = held_vis_q;
		cmd.op   = ops_pkg::OP_SKIP;
		cmd.opac = '0;
		cmd.det  = det;
		if (used) begin
			if (det.det_visible) begin
				cmd.op = sv_q ? ops_pkg::OP_SMOOTH : ops_pkg::OP_LOAD;
				sv_d   = 1'b1;
				miss_d = '0;
				hv_d   = 1'b1;
			end else begin
				miss_d = miss_inc;
				if (sv_q && miss_inc <= ops_pkg::MISS_W'(ops_pkg::HOLD_FRAMES)) begin
					cmd.op   = ops_pkg::OP_OPAC;
					cmd.opac = ops_pkg::OPAC_W'(ops_pkg::OPAC_ONE);
					hv_d     = 1'b1;
				end else if (sv_q && miss_inc <= ops_pkg::MISS_W'(ops_pkg::FADE_END)) begin
					cmd.op   = ops_pkg::OP_OPAC;
					cmd.opac = ops_pkg::FADE_TBL[fade_left[ops_pkg::FADE_IDX_W-1:0]];
					hv_d     = 1'b1;
				end else begin
					// no smoothed placement left: pass the raw detection
					cmd.op = ops_pkg::OP_RAW;
					sv_d   = 1'b0;
					hv_d   = 1'b0;
				end
			end
		end
	end

	// interval register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= ops_pkg::PHASE_W'(ops_pkg::INTERVAL_RESET);
		end else if (cfg_wr_en) begin
			interval_q <= cfg_wr_data;
		end
	end

	// tracking state, advanced per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			sv_q       <= 1'b0;
			miss_q     <= '0;
			held_vis_q <= 1'b0;
		end else if (cmd_wr) begin
			phase_q    <= ph_next;
			sv_q       <= sv_d;
			miss_q     <= miss_d;
			held_vis_q <= hv_d;
		end
	end

endmodule

### design/ops_cmd_queue.sv
module ops_cmd_queue #(
	parameter int DEPTH = ops_pkg::CMDQ_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ops_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output ops_pkg::cmd_t rd_data,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ops_pkg::cmd_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### design/ops_back.sv
module ops_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  ops_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output ops_pkg::res_item_t res,
	output logic               empty,
	input  logic               pop
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_ADD   = 5'b00100,
		ST_APPLY = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	localparam logic signed [ops_pkg::FRAC_BITS:0] ALPHA_S =
		(ops_pkg::FRAC_BITS + 1)'(ops_pkg::ALPHA_Q);
	localparam logic signed [ops_pkg::PROD_W-1:0] HALF_S =
		ops_pkg::PROD_W'(1) << (ops_pkg::FRAC_BITS - 1);
	localparam logic signed [ops_pkg::SUM_W-1:0] FIELD_MAX =
		ops_pkg::SUM_W'((1 << (ops_pkg::FIELD_W - 1)) - 1);
	localparam logic signed [ops_pkg::SUM_W-1:0] FIELD_MIN =
		ops_pkg::SUM_W'(-(1 << (ops_pkg::FIELD_W - 1)));
	localparam logic signed [ops_pkg::SUM_W-1:0] OPAC_HI = ops_pkg::SUM_W'(ops_pkg::OPAC_MAX);

	state_t                             state_q;
	ops_pkg::cmd_t                      cur_q;
	logic [ops_pkg::FLD_W-1:0]          fld_q;
	logic signed [ops_pkg::PROD_W-1:0]  prod_q;
	ops_pkg::fields_t                   smooth_q;
	ops_pkg::fields_t                   held_q;
	logic                               held_vis_q;
	ops_pkg::res_item_t                 res_q;
	logic                               res_valid_q;

	ops_pkg::fields_t                   det_f;
	logic [ops_pkg::FIELD_W-1:0]        s_k;
	logic [ops_pkg::FIELD_W-1:0]        d_k;
	logic signed [ops_pkg::FIELD_W:0]   diff;
	logic signed [ops_pkg::PROD_W-1:0]  prod_d;
	logic signed [ops_pkg::PROD_W-1:0]  rnd;
	logic signed [ops_pkg::PROD_W-1:0]  shifted;
	logic signed [ops_pkg::SUM_W-1:0]   delta;
	logic signed [ops_pkg::SUM_W-1:0]   sum;
	logic signed [ops_pkg::SUM_W-1:0]   lo;
	logic signed [ops_pkg::SUM_W-1:0]   hi;
	logic                               is_opac;
	logic [ops_pkg::FIELD_W-1:0]        ema_val;
	logic                               last_fld;
	logic                               emit_go;
	ops_pkg::fields_t                   opac_f;

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign det_f    = ops_pkg::det_fields(cur_q.det);
	assign last_fld = (fld_q == ops_pkg::FLD_W'(ops_pkg::NFIELDS - 1));
	assign emit_go  = (state_q == ST_EMIT) && (!res_valid_q || pop);
	assign res      = res_q;
	assign empty    = ~res_valid_q;

	// one field of the exponential average: multiply, then round and clamp
	always_comb begin
		s_k     = smooth_q[fld_q];
		d_k     = det_f[fld_q];
		diff    = $signed({d_k[ops_pkg::FIELD_W-1], d_k}) - $signed({s_k[ops_pkg::FIELD_W-1], s_k});
		prod_d  = ops_pkg::PROD_W'(diff) * ops_pkg::PROD_W'(ALPHA_S);
		rnd     = prod_q + HALF_S;
		shifted = rnd >>> ops_pkg::FRAC_BITS;
		delta   = shifted[ops_pkg::SUM_W-1:0];
		sum     = $signed({{2{s_k[ops_pkg::FIELD_W-1]}}, s_k}) + delta;
		is_opac = (fld_q == ops_pkg::FLD_W'(ops_pkg::OPAC_IDX));
		lo      = is_opac ? '0 : FIELD_MIN;
		hi      = is_opac ? OPAC_HI : FIELD_MAX;
		if (sum < lo) begin
			ema_val = lo[ops_pkg::FIELD_W-1:0];
		end else if (sum > hi) begin
			ema_val = hi[ops_pkg::FIELD_W-1:0];
		end else begin
			ema_val = sum[ops_pkg::FIELD_W-1:0];
		end
	end

	// smoothed placement with the new opacity
	always_comb begin
		opac_f = smooth_q;
		opac_f[ops_pkg::OPAC_IDX] = ops_pkg::FIELD_W'(cur_q.opac);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fld_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					fld_q <= '0;
					if (cmd_valid) begin
						state_q <= (cmd.op == ops_pkg::OP_SMOOTH) ? ST_MUL : ST_APPLY;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (last_fld) begin
						fld_q   <= '0;
						state_q <= ST_APPLY;
					end else begin
						fld_q   <= fld_q + ops_pkg::FLD_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_APPLY: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// shown flag and result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vis_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_APPLY) begin
				case (cur_q.op)
					ops_pkg::OP_SKIP: held_vis_q <= held_vis_q;
					ops_pkg::OP_RAW:  held_vis_q <= cur_q.det.det_visible;
					default:          held_vis_q <= 1'b1;
				endcase
			end
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// placement data
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_d;
		end
		if (state_q == ST_ADD) begin
			smooth_q[fld_q] <= ema_val;
		end
		if (state_q == ST_APPLY) begin
			case (cur_q.op)
				ops_pkg::OP_RAW: begin
					held_q <= det_f;
				end
				ops_pkg::OP_LOAD: begin
					smooth_q <= det_f;
					held_q   <= det_f;
				end
				ops_pkg::OP_SMOOTH: begin
					held_q <= smooth_q;
				end
				ops_pkg::OP_OPAC: begin
					smooth_q <= opac_f;
					held_q   <= opac_f;
				end
				default: begin
					held_q <= held_q;
				end
			endcase
		end
		if (emit_go) begin
			res_q <= ops_pkg::make_res(held_vis_q, held_q, cur_q.op != ops_pkg::OP_SKIP);
		end
	end

endmodule

### design/overlay_placement_smoother.sv
// channel   direction  handshake               word
// det       in         push / full             ops_pkg::det_item_t, one video frame
// res       out        pop / empty             ops_pkg::res_item_t, placement to show
// cfg       in         cfg_wr_en, cfg_wr_data  detect_interval, write only
//
// The front end classifies a frame in the cycle it is accepted and queues a command;
// it takes a new frame every cycle while the command queue has room.
// The back end ends one frame before taking the next and smooths the six fields in turn
// (one shared multiplier, a multiply and an add step each); that sets the sustained rate.
// A finished result waits in the output register; the back end stalls only on the next one.
// Reset is asynchronous; no clearing pass, the block is ready right after reset.
module overlay_placement_smoother #(
	parameter int CMDQ_DEPTH = ops_pkg::CMDQ_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  ops_pkg::det_item_t          det,
	output logic                        empty,
	input  logic                        pop,
	output ops_pkg::res_item_t          res,
	input  logic                        cfg_wr_en,
	input  logic [ops_pkg::PHASE_W-1:0] cfg_wr_data
);

	logic          cmd_wr;
	logic          cmd_full;
	logic          cmd_empty;
	logic          cmd_pop;
	ops_pkg::cmd_t cmd_in;
	ops_pkg::cmd_t cmd_out;

	assign full = cmd_full;

	// frame classification
	ops_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.det         (det),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_full    (cmd_full),
		.cmd_wr      (cmd_wr),
		.cmd         (cmd_in)
	);

	// command queue
	ops_cmd_queue #(
		.DEPTH (CMDQ_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_wr),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	// smoothing and output
	ops_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (~cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res       (res),
		.empty     (empty),
		.pop       (pop)
	);

	// a frame whose detection was skipped always shows the overlay
	a_skip_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !res.detection_used) |-> res.out_visible)
		else $error("skipped frame result with overlay hidden");

	// front never writes into a full queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_wr |-> !cmd_full)
		else $error("command written while queue full");

	// back only fetches when a command is waiting
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command fetched from empty queue");

endmodule
